FILE: hdl/link_count_window_sum_assert.svh
// ----------------------------------------------------------------------------
// link count window sum assertion macros
// shared concurrent assertion forms, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef LINK_COUNT_WINDOW_SUM_ASSERT_SVH
`define LINK_COUNT_WINDOW_SUM_ASSERT_SVH

// same-cycle implication
`define LCWS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lcws assertion failed");

// next-cycle implication
`define LCWS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lcws assertion failed");

`endif

FILE: hdl/lcws_pkg.sv
// ----------------------------------------------------------------------------
// lcws_pkg
// sizes, word types, codes and the command format shared by all lcws modules
// ----------------------------------------------------------------------------
package lcws_pkg;

    // table dimensions
    localparam int MAX_DAYS   = 64;
    localparam int MAX_NODES  = 16;
    localparam int ROW_DEPTH  = MAX_DAYS * MAX_NODES;
    localparam int CELL_DEPTH = ROW_DEPTH * MAX_NODES;
    localparam int DAY_AW     = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
    localparam int NODE_AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int ROW_AW     = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

    // field and value widths
    localparam int DAY_W  = 7;
    localparam int NODE_W = 5;
    localparam int LAG_W  = 7;
    localparam int CNT_W  = 16;
    localparam int CELL_W = 32;
    localparam int ROW_W  = 36;
    localparam int SUM_W  = 48;
    localparam int STEP_W = 7;

    // action codes
    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_LAG  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_NUM_DAYS   = 2'd0;
    localparam logic [1:0] REG_NUM_NODES  = 2'd1;
    localparam logic [1:0] REG_LAG_LENGTH = 2'd2;

    // register reset values
    localparam logic [DAY_W-1:0]  NUM_DAYS_RST   = 7'd64;
    localparam logic [NODE_W-1:0] NUM_NODES_RST  = 5'd16;
    localparam logic [LAG_W-1:0]  LAG_LENGTH_RST = 7'd1;

    typedef struct packed {
        logic [1:0]        action;
        logic [DAY_W-1:0]  day_index;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] target_node;
        logic [CNT_W-1:0]  count_value;
    } in_word_t;

    typedef struct packed {
        logic [SUM_W-1:0] result_value;
        logic             status;
    } out_word_t;

    typedef struct packed {
        logic [DAY_W-1:0]  num_days;
        logic [NODE_W-1:0] num_nodes;
        logic [LAG_W-1:0]  lag_length;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_ERR,
        OP_ADD,
        OP_READ,
        OP_LAG
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CELL_AW-1:0] cell_addr;
        logic [ROW_AW-1:0]  row_addr;
        logic [CNT_W-1:0]   count;
        logic [STEP_W-1:0]  steps;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_CALC,
        ST_WR,
        ST_LAG
    } bst_t;

endpackage

FILE: hdl/lcws_front.sv
// ----------------------------------------------------------------------------
// lcws_front
// accepts input words, range-checks them and turns them into table commands
// ----------------------------------------------------------------------------
module lcws_front import lcws_pkg::*; (
    input  cfg_t     cfg,
    input  logic     enable,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_data,
    input  logic     q_ready,
    output logic     push,
    output cmd_t     cmd
);

    logic               day_ok;
    logic               src_ok;
    logic               tgt_ok;
    logic               err;
    logic [DAY_AW-1:0]  day0;
    logic [NODE_AW-1:0] src0;
    logic [NODE_AW-1:0] tgt0;
    logic [ROW_AW-1:0]  row;
    logic [LAG_W-1:0]   lag_eff;
    logic [LAG_W-1:0]   lag_m1;
    logic [DAY_W-1:0]   first;
    logic [DAY_AW-1:0]  first0;

    assign s_ready = enable && q_ready;
    assign push    = s_valid && s_ready;

    always_comb begin
        day_ok = (s_data.day_index != '0) && (s_data.day_index <= cfg.num_days)
                 && (int'(s_data.day_index) <= MAX_DAYS);
        src_ok = (s_data.source_node != '0) && (s_data.source_node <= cfg.num_nodes)
                 && (int'(s_data.source_node) <= MAX_NODES);
        tgt_ok = (s_data.target_node != '0) && (s_data.target_node <= cfg.num_nodes)
                 && (int'(s_data.target_node) <= MAX_NODES);
        err    = (s_data.action != ACT_ADD && s_data.action != ACT_READ
                  && s_data.action != ACT_LAG)
                 || !day_ok || !src_ok || (s_data.action != ACT_LAG && !tgt_ok);

        day0 = DAY_AW'(s_data.day_index - 7'd1);
        src0 = NODE_AW'(s_data.source_node - 5'd1);
        tgt0 = NODE_AW'(s_data.target_node - 5'd1);
        row  = ROW_AW'(int'(day0) * MAX_NODES + int'(src0));

        // window start, clipped at day 1
        lag_eff = (cfg.lag_length == '0) ? 7'd1 : cfg.lag_length;
        lag_m1  = lag_eff - 7'd1;
        first   = (s_data.day_index > lag_m1) ? (s_data.day_index - lag_m1) : 7'd1;
        first0  = DAY_AW'(first - 7'd1);

        cmd.cell_addr = CELL_AW'(int'(row) * MAX_NODES + int'(tgt0));
        cmd.count     = s_data.count_value;
        cmd.steps     = STEP_W'(s_data.day_index - first);
        if (err) begin
            cmd.op       = OP_ERR;
            cmd.row_addr = row;
        end else if (s_data.action == ACT_LAG) begin
            cmd.op       = OP_LAG;
            cmd.row_addr = ROW_AW'(int'(first0) * MAX_NODES + int'(src0));
        end else if (s_data.action == ACT_READ) begin
            cmd.op       = OP_READ;
            cmd.row_addr = row;
        end else begin
            cmd.op       = OP_ADD;
            cmd.row_addr = row;
        end
    end

endmodule

FILE: hdl/lcws_queue.sv
// ----------------------------------------------------------------------------
// lcws_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module lcws_queue import lcws_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign in_ready  = (count_reg != (PTR_W+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: hdl/lcws_back.sv
// ----------------------------------------------------------------------------
// lcws_back
// executes table commands on the cell and row-total memories, owns the
// result register and the clearing pass after reset
// ----------------------------------------------------------------------------
`include "link_count_window_sum_assert.svh"

module lcws_back import lcws_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  cmd_t      q_cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    output logic      clear_done
);

    // memories
    logic [CELL_W-1:0] cell_mem [CELL_DEPTH];
    logic [ROW_W-1:0]  row_mem  [ROW_DEPTH];
    logic [CELL_W-1:0] cell_rdata_reg;
    logic [ROW_W-1:0]  row_rdata_reg;

    logic               cell_we, cell_ren;
    logic [CELL_AW-1:0] cell_waddr, cell_raddr;
    logic [CELL_W-1:0]  cell_wdata;
    logic               row_we, row_ren;
    logic [ROW_AW-1:0]  row_waddr, row_raddr;
    logic [ROW_W-1:0]   row_wdata;

    // sequencer state
    bst_t               state_reg, state_next;
    logic [CELL_AW-1:0] clr_addr_reg, clr_addr_next;
    op_t                op_reg, op_next;
    logic [CELL_AW-1:0] cell_addr_reg, cell_addr_next;
    logic [ROW_AW-1:0]  row_addr_reg, row_addr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CELL_W-1:0]  neu_reg, neu_next;
    logic [CNT_W-1:0]   delta_reg, delta_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic               pend_reg, pend_next;
    logic [SUM_W-1:0]   acc_reg, acc_next;

    logic               m_valid_reg, m_valid_next;
    out_word_t          m_data_reg;
    logic               out_free, out_load;
    out_word_t          out_word;

    logic [CELL_W:0]    cell_sum;
    logic [ROW_W:0]     row_sum;
    logic [ROW_W-1:0]   row_new;
    logic [SUM_W:0]     acc_sum;

    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign clear_done = (state_reg != ST_CLEAR);

    // saturating arithmetic
    always_comb begin
        cell_sum = {1'b0, cell_rdata_reg} + (CELL_W+1)'(cnt_reg);
        row_sum  = {1'b0, row_rdata_reg} + (ROW_W+1)'(delta_reg);
        row_new  = row_sum[ROW_W] ? '1 : row_sum[ROW_W-1:0];
        acc_sum  = {1'b0, acc_reg} + (SUM_W+1)'(row_rdata_reg);
    end

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        op_next        = op_reg;
        cell_addr_next = cell_addr_reg;
        row_addr_next  = row_addr_reg;
        cnt_next       = cnt_reg;
        neu_next       = neu_reg;
        delta_next     = delta_reg;
        steps_next     = steps_reg;
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        q_ready        = 1'b0;
        cell_we        = 1'b0;
        cell_waddr     = cell_addr_reg;
        cell_wdata     = neu_reg;
        cell_ren       = 1'b0;
        cell_raddr     = q_cmd.cell_addr;
        row_we         = 1'b0;
        row_waddr      = row_addr_reg;
        row_wdata      = row_new;
        row_ren        = 1'b0;
        row_raddr      = q_cmd.row_addr;
        out_load       = 1'b0;
        out_word       = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                cell_we    = 1'b1;
                cell_waddr = clr_addr_reg;
                cell_wdata = '0;
                if (int'(clr_addr_reg) < ROW_DEPTH) begin
                    row_we    = 1'b1;
                    row_waddr = clr_addr_reg[ROW_AW-1:0];
                    row_wdata = '0;
                end
                if (int'(clr_addr_reg) == CELL_DEPTH - 1) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_cmd.op)
                        OP_ERR: begin
                            if (out_free) begin
                                q_ready         = 1'b1;
                                out_load        = 1'b1;
                                out_word.status = 1'b1;
                            end
                        end
                        OP_ADD, OP_READ: begin
                            q_ready        = 1'b1;
                            cell_ren       = 1'b1;
                            row_ren        = 1'b1;
                            op_next        = q_cmd.op;
                            cell_addr_next = q_cmd.cell_addr;
                            row_addr_next  = q_cmd.row_addr;
                            cnt_next       = q_cmd.count;
                            state_next     = ST_RD;
                        end
                        OP_LAG: begin
                            q_ready       = 1'b1;
                            row_addr_next = q_cmd.row_addr;
                            steps_next    = q_cmd.steps;
                            pend_next     = 1'b0;
                            acc_next      = '0;
                            state_next    = ST_LAG;
                        end
                        default: begin
                            q_ready = 1'b0;
                        end
                    endcase
                end
            end
            ST_RD: begin
                if (op_reg == OP_READ) begin
                    if (out_free) begin
                        out_load              = 1'b1;
                        out_word.result_value = SUM_W'(cell_rdata_reg);
                        state_next            = ST_IDLE;
                    end
                end else begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                neu_next   = cell_sum[CELL_W] ? '1 : cell_sum[CELL_W-1:0];
                delta_next = cell_sum[CELL_W] ? CNT_W'({CELL_W{1'b1}} - cell_rdata_reg)
                                              : cnt_reg;
                state_next = ST_WR;
            end
            ST_WR: begin
                if (out_free) begin
                    cell_we    = 1'b1;
                    row_we     = 1'b1;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LAG: begin
                row_raddr = row_addr_reg;
                pend_next = (steps_reg != '0);
                if (steps_reg != '0) begin
                    row_ren       = 1'b1;
                    row_addr_next = ROW_AW'(int'(row_addr_reg) + MAX_NODES);
                    steps_next    = steps_reg - 1'b1;
                end
                if (pend_reg) begin
                    acc_next = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
                end
                if (steps_reg == '0 && !pend_reg && out_free) begin
                    out_load              = 1'b1;
                    out_word.result_value = acc_reg;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        cell_addr_reg <= cell_addr_next;
        row_addr_reg  <= row_addr_next;
        cnt_reg       <= cnt_next;
        neu_reg       <= neu_next;
        delta_reg     <= delta_next;
        steps_reg     <= steps_next;
        acc_reg       <= acc_next;
        if (out_load) begin
            m_data_reg <= out_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (cell_we) begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        if (cell_ren) begin
            cell_rdata_reg <= cell_mem[cell_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (row_ren) begin
            row_rdata_reg <= row_mem[row_raddr];
        end
    end

    `LCWS_ASSERT_IMP(a_no_pop_in_clear, state_reg == ST_CLEAR, !q_ready)
    `LCWS_ASSERT_IMP(a_err_zero, m_valid_reg && m_data_reg.status, m_data_reg.result_value == '0)
    `LCWS_ASSERT_NXT(a_add_done, (state_reg == ST_WR) && out_free, m_valid_reg && !m_data_reg.status)
    `LCWS_ASSERT_IMP(a_pend_in_lag, pend_reg, state_reg == ST_LAG)

endmodule

FILE: hdl/link_count_window_sum.sv
// ----------------------------------------------------------------------------
// link_count_window_sum
// per-day link count table with a lagged row-total query
// ----------------------------------------------------------------------------
// After reset the block sweeps both tables to zero, one cell per cycle, over all
// MAX_DAYS*MAX_NODES*MAX_NODES cells (16384 as built); s_ready stays low until
// the sweep ends, while register writes are taken throughout. Each word then
// takes one pass through the back-end sequencer: a rejected word returns an
// error result, a cell read reads the cell and returns it, an add reads,
// saturates, then writes cell and row total, and a lagged query reads the
// row totals of the prior days summed (up to lag_length-1), one row-total
// memory read per cycle, adding each total once its read returns. A
// two-entry queue sits between the input check and the sequencer, and a
// result register sits on the output, so input words keep being taken while
// a result waits, as long as the queue has room.
// ----------------------------------------------------------------------------
module link_count_window_sum import lcws_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // register file
    logic [DAY_W-1:0]  num_days_reg;
    logic [NODE_W-1:0] num_nodes_reg;
    logic [LAG_W-1:0]  lag_length_reg;
    logic              reg_write;
    cfg_t              cfg;

    // front to queue to back
    logic              clear_done;
    logic              push;
    logic              q_in_ready;
    cmd_t              f_cmd;
    logic              q_valid;
    logic              q_ready;
    cmd_t              q_cmd;

    // apb access: no wait states
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_days_reg   <= NUM_DAYS_RST;
            num_nodes_reg  <= NUM_NODES_RST;
            lag_length_reg <= LAG_LENGTH_RST;
        end else if (reg_write) begin
            // writes beyond the register list are dropped
            unique case (paddr[3:2])
                REG_NUM_DAYS:   num_days_reg   <= pwdata[DAY_W-1:0];
                REG_NUM_NODES:  num_nodes_reg  <= pwdata[NODE_W-1:0];
                REG_LAG_LENGTH: lag_length_reg <= pwdata[LAG_W-1:0];
                default:        num_days_reg   <= num_days_reg;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_NUM_DAYS:   prdata = 32'(num_days_reg);
            REG_NUM_NODES:  prdata = 32'(num_nodes_reg);
            REG_LAG_LENGTH: prdata = 32'(lag_length_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.num_days   = num_days_reg;
    assign cfg.num_nodes  = num_nodes_reg;
    assign cfg.lag_length = lag_length_reg;

    // range check and command build
    lcws_front u_front (
        .cfg     (cfg),
        .enable  (clear_done),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_ready (q_in_ready),
        .push    (push),
        .cmd     (f_cmd)
    );

    // decoupling queue
    lcws_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push),
        .in_ready  (q_in_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    // table sequencer and result register
    lcws_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_cmd      (q_cmd),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .clear_done (clear_done)
    );

endmodule
